// File: src/stli_pkg.sv
// package for the sorted table linear interpolator
// holds types, codes and the controller to datapath command and status structs
`default_nettype none
package stli_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 1024;

  typedef enum logic [2:0] {
    ST_EXACT       = 3'd0,
    ST_INTERP      = 3'd1,
    ST_EXTRAP      = 3'd2,
    ST_BELOW       = 3'd3,
    ST_GAP         = 3'd4,
    ST_UNBRACKETED = 3'd5,
    ST_LOADED      = 3'd6,
    ST_FULL        = 3'd7
  } status_e;

  typedef enum logic [2:0] {
    IDX_HOLD, IDX_LAST, IDX_LASTM1, IDX_DEC, IDX_PTR, IDX_INC
  } idx_sel_e;

  typedef enum logic [1:0] {
    SP_HOLD, SP_CUR, SP_CURM1
  } sptr_sel_e;

  typedef enum logic [2:0] {
    RI_CUR, RI_CURM1, RI_LASTM1, RI_LAST, RI_CNT
  } ridx_sel_e;

  typedef enum logic [1:0] {
    RV_MVAL, RV_RD, RV_LINE
  } rval_sel_e;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_RD_LAST, S_RD_LM1, S_CHK_HI, S_SCAN, S_WALK_A,
    S_WALK_B, S_GAP_CHK, S_DIFF, S_MUL, S_DIV_INIT, S_DIV, S_FIX, S_FINISH
  } state_e;

  typedef struct packed {
    logic      capture;
    idx_sel_e  idx_sel;
    logic      ld_a;
    logic      ld_b;
    logic      wr_en;
    sptr_sel_e sptr_sel;
    logic      st_load;
    status_e   st;
    logic      ri_load;
    ridx_sel_e ri_sel;
    logic      rv_load;
    rval_sel_e rv_sel;
    logic      diff_en;
    logic      mul_en;
    logic      div_start;
    logic      div_step;
    logic      out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_query;
    logic q_neg;
    logic full;
    logic cnt_ge2;
    logic q_gt_b;
    logic b_le_a;
    logic rd_eq_q;
    logic idx_zero;
    logic idx_end;
    logic bracket;
    logic gap;
    logic div_last;
  } dp_stat_t;

endpackage
`default_nettype wire

// File: src/stli_ram.sv
// generic simple dual port ram, one write port and one registered read port
// no dependencies
`default_nettype none
module stli_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// File: src/stli_ctrl.sv
// controller state machine of the interpolator
// depends on stli_pkg for the state enum and the command and status structs
`default_nettype none
module stli_ctrl
  import stli_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_valid_d = cmd_o.out_load ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:     if (in_valid_i) state_d = S_DISPATCH;
      S_DISPATCH: begin
        if (!stat_i.is_query || stat_i.q_neg) state_d = S_FINISH;
        else state_d = S_RD_LAST;
      end
      S_RD_LAST:  state_d = S_RD_LM1;
      S_RD_LM1:   state_d = S_CHK_HI;
      S_CHK_HI: begin
        if (stat_i.q_gt_b) begin
          state_d = (!stat_i.cnt_ge2 || stat_i.b_le_a) ? S_FINISH : S_DIFF;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat_i.rd_eq_q) state_d = S_FINISH;
        else if (stat_i.idx_zero) state_d = S_WALK_A;
      end
      S_WALK_A:   state_d = stat_i.idx_end ? S_FINISH : S_WALK_B;
      S_WALK_B: begin
        if (stat_i.bracket) state_d = S_GAP_CHK;
        else if (stat_i.idx_end) state_d = S_FINISH;
      end
      S_GAP_CHK:  state_d = stat_i.gap ? S_FINISH : S_DIFF;
      S_DIFF:     state_d = S_MUL;
      S_MUL:      state_d = S_DIV_INIT;
      S_DIV_INIT: state_d = S_DIV;
      S_DIV:      if (stat_i.div_last) state_d = S_FIX;
      S_FIX:      state_d = S_FINISH;
      S_FINISH:   if (slot_free) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.idx_sel  = IDX_HOLD;
    cmd_o.sptr_sel = SP_HOLD;
    cmd_o.st       = ST_UNBRACKETED;
    cmd_o.ri_sel   = RI_CUR;
    cmd_o.rv_sel   = RV_MVAL;
    case (state_q)
      S_IDLE:     cmd_o.capture = in_valid_i;
      S_DISPATCH: begin
        if (!stat_i.is_query) begin
          cmd_o.st_load = 1'b1;
          cmd_o.ri_load = 1'b1;
          if (stat_i.full) begin
            cmd_o.st     = ST_FULL;
            cmd_o.ri_sel = RI_LAST;
          end else begin
            cmd_o.wr_en   = 1'b1;
            cmd_o.st      = ST_LOADED;
            cmd_o.ri_sel  = RI_CNT;
            cmd_o.rv_load = 1'b1;
            cmd_o.rv_sel  = RV_MVAL;
          end
        end else if (stat_i.q_neg) begin
          cmd_o.st_load = 1'b1;
          cmd_o.st      = ST_BELOW;
        end else begin
          cmd_o.idx_sel = IDX_LAST;
        end
      end
      S_RD_LAST: begin
        cmd_o.ld_b    = 1'b1;
        cmd_o.idx_sel = IDX_LASTM1;
      end
      S_RD_LM1: begin
        cmd_o.ld_a    = 1'b1;
        cmd_o.idx_sel = IDX_LAST;
      end
      S_CHK_HI: begin
        if (stat_i.q_gt_b) begin
          cmd_o.st_load = 1'b1;
          if (!stat_i.cnt_ge2 || stat_i.b_le_a) begin
            cmd_o.st = ST_UNBRACKETED;
          end else begin
            cmd_o.st      = ST_EXTRAP;
            cmd_o.ri_load = 1'b1;
            cmd_o.ri_sel  = RI_LASTM1;
          end
        end
      end
      S_SCAN: begin
        if (stat_i.rd_eq_q) begin
          cmd_o.st_load = 1'b1;
          cmd_o.st      = ST_EXACT;
          cmd_o.ri_load = 1'b1;
          cmd_o.ri_sel  = RI_CUR;
          cmd_o.rv_load = 1'b1;
          cmd_o.rv_sel  = RV_RD;
        end else if (stat_i.idx_zero) begin
          cmd_o.idx_sel = IDX_PTR;
        end else begin
          cmd_o.idx_sel = IDX_DEC;
        end
      end
      S_WALK_A: begin
        cmd_o.ld_a = 1'b1;
        if (stat_i.idx_end) begin
          cmd_o.st_load  = 1'b1;
          cmd_o.st       = ST_UNBRACKETED;
          cmd_o.ri_load  = 1'b1;
          cmd_o.ri_sel   = RI_CUR;
          cmd_o.sptr_sel = SP_CUR;
        end else begin
          cmd_o.idx_sel = IDX_INC;
        end
      end
      S_WALK_B: begin
        if (stat_i.bracket) begin
          cmd_o.ld_b     = 1'b1;
          cmd_o.sptr_sel = SP_CURM1;
          cmd_o.st_load  = 1'b1;
          cmd_o.st       = ST_INTERP;
          cmd_o.ri_load  = 1'b1;
          cmd_o.ri_sel   = RI_CURM1;
        end else begin
          cmd_o.ld_a = 1'b1;
          if (stat_i.idx_end) begin
            cmd_o.st_load  = 1'b1;
            cmd_o.st       = ST_UNBRACKETED;
            cmd_o.ri_load  = 1'b1;
            cmd_o.ri_sel   = RI_CUR;
            cmd_o.sptr_sel = SP_CUR;
          end else begin
            cmd_o.idx_sel = IDX_INC;
          end
        end
      end
      S_GAP_CHK: begin
        if (stat_i.gap) begin
          cmd_o.st_load = 1'b1;
          cmd_o.st      = ST_GAP;
        end
      end
      S_DIFF:     cmd_o.diff_en = 1'b1;
      S_MUL:      cmd_o.mul_en = 1'b1;
      S_DIV_INIT: cmd_o.div_start = 1'b1;
      S_DIV:      cmd_o.div_step = 1'b1;
      S_FIX: begin
        cmd_o.rv_load = 1'b1;
        cmd_o.rv_sel  = RV_LINE;
      end
      S_FINISH:   cmd_o.out_load = slot_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: src/stli_datapath.sv
// datapath of the interpolator: tables, pointers, line arithmetic, divider, result
// depends on stli_pkg and stli_ram
`default_nettype none
module stli_datapath
  import stli_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  input  wire logic [30:0]        cfg_data_i,
  input  wire logic               action_i,
  input  wire logic signed [31:0] position_i,
  input  wire logic [31:0]        map_value_i,
  input  wire dp_cmd_t            cmd_i,
  output dp_stat_t                stat_o,
  output logic [2:0]              status_o,
  output logic [31:0]             result_value_o,
  output logic [9:0]              entry_index_o,
  output logic                    success_o
);

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  logic [30:0]        max_gap_q;
  logic               act_q;
  logic signed [31:0] q_q;
  logic [31:0]        mval_q;
  logic [CW-1:0]      count_q;
  logic [IW-1:0]      sptr_q, idx_q, idx_d;
  logic               rd_zero_q;
  logic [31:0]        pos_ram, val_ram;
  logic signed [31:0] rd_pos;
  logic [31:0]        rd_val;
  logic signed [31:0] pa_q, pb_q;
  logic [31:0]        va_q, vb_q;
  logic [31:0]        adv_q, adq_q, dp_q;
  logic               neg_q, zero_q;
  logic [63:0]        prod_q, dvd_q;
  logic [31:0]        rem_q;
  logic [5:0]         dcnt_q;
  status_e            res_st_q;
  logic [IW-1:0]      res_idx_q;
  logic [31:0]        res_val_q;

  logic [CW-1:0]      last_c, lastm1_c;
  logic [CW:0]        idx_p1;
  logic [32:0]        dp_w, dq_w, dv_w;
  logic [32:0]        rem_sh, rem_sub;
  logic               ge;
  logic [64:0]        off_w, sum_w;
  logic [31:0]        line_val;
  logic [IW-1:0]      ri_d;
  logic [IW+9:0]      idx_ext;

  assign last_c   = count_q - 1'b1;
  assign lastm1_c = (count_q >= CW'(2)) ? (count_q - CW'(2)) : '0;
  assign idx_p1   = {{(CW + 1 - IW){1'b0}}, idx_q} + 1'b1;

  always_comb begin
    case (cmd_i.idx_sel)
      IDX_LAST:   idx_d = last_c[IW-1:0];
      IDX_LASTM1: idx_d = lastm1_c[IW-1:0];
      IDX_DEC:    idx_d = idx_q - 1'b1;
      IDX_PTR:    idx_d = sptr_q;
      IDX_INC:    idx_d = idx_q + 1'b1;
      default:    idx_d = idx_q;
    endcase
  end

  stli_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (count_q[IW-1:0]),
    .wdata_i (q_q),
    .raddr_i (idx_d),
    .rdata_o (pos_ram)
  );

  stli_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (count_q[IW-1:0]),
    .wdata_i (mval_q),
    .raddr_i (idx_d),
    .rdata_o (val_ram)
  );

  // entry zero is fixed at the origin
  assign rd_pos = rd_zero_q ? '0 : pos_ram;
  assign rd_val = rd_zero_q ? '0 : val_ram;

  assign dp_w = {pb_q[31], pb_q} - {pa_q[31], pa_q};
  assign dq_w = {q_q[31], q_q} - {pa_q[31], pa_q};
  assign dv_w = {1'b0, vb_q} - {1'b0, va_q};

  assign stat_o.is_query = act_q;
  assign stat_o.q_neg    = q_q[31];
  assign stat_o.full     = (count_q >= CW'(TABLE_DEPTH));
  assign stat_o.cnt_ge2  = (count_q >= CW'(2));
  assign stat_o.q_gt_b   = (q_q > pb_q);
  assign stat_o.b_le_a   = (pb_q <= pa_q);
  assign stat_o.rd_eq_q  = (rd_pos == q_q);
  assign stat_o.idx_zero = (idx_q == '0);
  assign stat_o.idx_end  = (idx_p1 >= {1'b0, count_q});
  assign stat_o.bracket  = (pa_q < q_q) && (q_q < rd_pos);
  assign stat_o.gap      = (dp_w > {2'b00, max_gap_q});
  assign stat_o.div_last = (dcnt_q == '0);

  // restoring divider, one quotient bit per cycle
  assign rem_sh  = {rem_q, dvd_q[63]};
  assign ge      = (rem_sh >= {1'b0, dp_q});
  assign rem_sub = ge ? (rem_sh - {1'b0, dp_q}) : rem_sh;

  assign off_w = {1'b0, dvd_q} + {64'd0, (rem_q != '0)};
  assign sum_w = {33'd0, va_q} + {1'b0, dvd_q};

  always_comb begin
    if (zero_q) begin
      line_val = va_q;
    end else if (neg_q) begin
      line_val = (off_w >= {33'd0, va_q}) ? '0 : (va_q - off_w[31:0]);
    end else begin
      line_val = (sum_w[64:32] != '0) ? 32'hFFFF_FFFF : sum_w[31:0];
    end
  end

  always_comb begin
    case (cmd_i.ri_sel)
      RI_CURM1:  ri_d = idx_q - 1'b1;
      RI_LASTM1: ri_d = lastm1_c[IW-1:0];
      RI_LAST:   ri_d = last_c[IW-1:0];
      RI_CNT:    ri_d = count_q[IW-1:0];
      default:   ri_d = idx_q;
    endcase
  end

  assign idx_ext = {10'd0, res_idx_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_gap_q <= 31'h7FFF_FFFF;
      count_q   <= CW'(1);
      sptr_q    <= '0;
      idx_q     <= '0;
      rd_zero_q <= 1'b1;
    end else begin
      if (cfg_valid_i) max_gap_q <= cfg_data_i;
      if (cmd_i.wr_en) count_q <= count_q + 1'b1;
      case (cmd_i.sptr_sel)
        SP_CUR:   sptr_q <= idx_q;
        SP_CURM1: sptr_q <= idx_q - 1'b1;
        default:  sptr_q <= sptr_q;
      endcase
      idx_q     <= idx_d;
      rd_zero_q <= (idx_d == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q     <= action_i;
      q_q       <= position_i;
      mval_q    <= map_value_i;
      res_idx_q <= '0;
      res_val_q <= '0;
    end
    if (cmd_i.ld_a) begin
      pa_q <= rd_pos;
      va_q <= rd_val;
    end
    if (cmd_i.ld_b) begin
      pb_q <= rd_pos;
      vb_q <= rd_val;
    end
    if (cmd_i.diff_en) begin
      dp_q  <= dp_w[31:0];
      adq_q <= dq_w[31:0];
      neg_q <= dv_w[32];
      adv_q <= dv_w[32] ? (32'd0 - dv_w[31:0]) : dv_w[31:0];
    end
    if (cmd_i.mul_en) begin
      prod_q <= {32'd0, adv_q} * {32'd0, adq_q};
      zero_q <= (adv_q == '0) || (adq_q == '0);
    end
    if (cmd_i.div_start) begin
      dvd_q  <= prod_q;
      rem_q  <= '0;
      dcnt_q <= 6'd63;
    end else if (cmd_i.div_step) begin
      dvd_q  <= {dvd_q[62:0], ge};
      rem_q  <= rem_sub[31:0];
      dcnt_q <= dcnt_q - 1'b1;
    end
    if (cmd_i.st_load) res_st_q <= cmd_i.st;
    if (cmd_i.ri_load) res_idx_q <= ri_d;
    if (cmd_i.rv_load) begin
      case (cmd_i.rv_sel)
        RV_RD:   res_val_q <= rd_val;
        RV_LINE: res_val_q <= line_val;
        default: res_val_q <= mval_q;
      endcase
    end
    if (cmd_i.out_load) begin
      status_o       <= res_st_q;
      result_value_o <= res_val_q;
      entry_index_o  <= idx_ext[9:0];
      success_o      <= (res_st_q inside {ST_EXACT, ST_INTERP, ST_EXTRAP, ST_LOADED});
    end
  end

endmodule
`default_nettype wire

// File: src/sorted_table_linear_interpolator_top.sv
// top level of the sorted table linear interpolator
// depends on stli_pkg, stli_ctrl, stli_datapath and stli_ram
//
// channel  direction  handshake                  payload
// in       input      in_valid_i / in_stall_o    action_i, position_i, map_value_i
// out      output     out_valid_o / out_stall_i  status_o, result_value_o,
//                                                entry_index_o, success_o
// cfg      input      cfg_valid_i / cfg_ready_o  cfg_data_i (max_gap)
//
// one transaction at a time; a load writes its entry in S_DISPATCH, then S_FINISH
// loads the output register; a query reads the last two entries, may scan for an
// exact match and walk the search pointer, and may end with the 64 step divider
// reset empties the table to the fixed origin entry; no clearing pass is needed
// a result held by out_stall_i stays in the output register while the next
// transaction is taken and worked on
`default_nettype none
module sorted_table_linear_interpolator_top
  import stli_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [30:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               action_i,
  input  wire logic signed [31:0] position_i,
  input  wire logic [31:0]        map_value_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [2:0]              status_o,
  output logic [31:0]             result_value_o,
  output logic [9:0]              entry_index_o,
  output logic                    success_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  stli_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  stli_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .action_i       (action_i),
    .position_i     (position_i),
    .map_value_i    (map_value_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .status_o       (status_o),
    .result_value_o (result_value_o),
    .entry_index_o  (entry_index_o),
    .success_o      (success_o)
  );

endmodule
`default_nettype wire

// File: test/sorted_table_linear_interpolator_top_tb.sv
// testbench for sorted_table_linear_interpolator_top: loads and queries with a
// behavioral table model, random idling, receiver hold-off, max_gap phases
// depends on stli_pkg and the top level rtl
`timescale 1ns / 100ps
`default_nettype none
module sorted_table_linear_interpolator_top_tb
  import stli_pkg::*;
;

  localparam int unsigned DEPTH = TABLE_DEPTH_DEF;
  localparam int unsigned WDOG_LIMIT = 30000;
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef enum logic [1:0] {J_ITEM, J_CFG, J_DRAIN} job_kind_e;

  typedef struct {
    job_kind_e         kind;
    logic              action;
    logic signed [31:0] pos;
    logic [31:0]       mval;
    logic [30:0]       gap;
  } job_t;

  typedef struct {
    status_e     status;
    logic [31:0] value;
    logic [9:0]  index;
    logic        ok;
  } lookup_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [30:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic action_i = 1'b0;
  logic signed [31:0] position_i = '0;
  logic [31:0] map_value_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [2:0] status_o;
  logic [31:0] result_value_o;
  logic [9:0] entry_index_o;
  logic success_o;

  sorted_table_linear_interpolator_top u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .action_i(action_i),
    .position_i(position_i), .map_value_i(map_value_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .status_o(status_o),
    .result_value_o(result_value_o), .entry_index_o(entry_index_o),
    .success_o(success_o)
  );

  always #5 clk_i = ~clk_i;

  // table model
  logic signed [31:0] pos_tab [DEPTH];
  logic [31:0] val_tab [DEPTH];
  int unsigned tab_count = 1;
  int unsigned walk_ptr = 0;
  logic [30:0] gap_limit = 31'h7FFF_FFFF;

  job_t pending[$];
  lookup_t lookups_due[$];

  bit in_fire, cfg_fire;
  int unsigned cyc = 0, idle_cyc = 0, hold_left = 0;
  bit hold_done = 0;
  int unsigned n_items = 0, n_results = 0, n_cfg = 0, mismatches = 0;
  int unsigned status_seen [8];

  function automatic logic [31:0] line_at(longint p1, logic [31:0] v1, longint p2,
                                          logic [31:0] v2, longint q);
    longint dv, dq;
    logic [63:0] dp, mdv, mdq, m, quo, rem, off;
    bit neg;
    dv = longint'(v2) - longint'(v1);
    dq = q - p1;
    dp = p2 - p1;
    mdv = (dv < 0) ? -dv : dv;
    mdq = (dq < 0) ? -dq : dq;
    m = mdv * mdq;
    quo = m / dp;
    rem = m % dp;
    neg = (dv < 0) != (dq < 0);
    if (m == 0) return v1;
    if (neg) begin
      off = quo + ((rem != 0) ? 64'd1 : 64'd0);
      if (off >= {32'b0, v1}) return 32'd0;
      return v1 - off[31:0];
    end
    if (quo > {32'b0, ~v1}) return 32'hFFFF_FFFF;
    return v1 + quo[31:0];
  endfunction

  function automatic lookup_t table_lookup(logic act, logic signed [31:0] q, logic [31:0] mv);
    lookup_t r;
    int unsigned last, i;
    bit found;
    longint p1, p2;
    r.status = ST_UNBRACKETED;
    r.value = '0;
    last = tab_count - 1;
    i = 0;
    found = 0;
    if (act == ACT_LOAD) begin
      if (tab_count >= DEPTH) begin
        r.status = ST_FULL;
        i = last;
      end else begin
        pos_tab[tab_count] = q;
        val_tab[tab_count] = mv;
        r.status = ST_LOADED;
        r.value = mv;
        i = tab_count;
        tab_count++;
      end
    end else if (q < pos_tab[0]) begin
      r.status = ST_BELOW;
    end else if (q > pos_tab[last]) begin
      if (tab_count < 2 || pos_tab[last] <= pos_tab[last-1]) begin
        r.status = ST_UNBRACKETED;
      end else begin
        r.status = ST_EXTRAP;
        i = last - 1;
        r.value = line_at(pos_tab[last-1], val_tab[last-1], pos_tab[last], val_tab[last], q);
      end
    end else begin
      i = tab_count;
      while (i > 0 && !found) begin
        i--;
        if (pos_tab[i] == q) found = 1;
      end
      if (found) begin
        r.status = ST_EXACT;
        r.value = val_tab[i];
      end else begin
        i = walk_ptr;
        while (i + 1 < tab_count && !(pos_tab[i] < q && q < pos_tab[i+1])) i++;
        walk_ptr = i;
        if (i + 1 >= tab_count) begin
          r.status = ST_UNBRACKETED;
        end else begin
          p1 = pos_tab[i];
          p2 = pos_tab[i+1];
          if (p2 - p1 > longint'(gap_limit)) begin
            r.status = ST_GAP;
          end else begin
            r.status = ST_INTERP;
            r.value = line_at(p1, val_tab[i], p2, val_tab[i+1], q);
          end
        end
      end
    end
    r.index = i[9:0];
    r.ok = (r.status == ST_EXACT || r.status == ST_INTERP || r.status == ST_EXTRAP ||
            r.status == ST_LOADED);
    return r;
  endfunction

  // stimulus building
  longint gen_max = 0;
  int unsigned gen_count = 1;
  longint gen_pos[$];

  task automatic add_item(logic act, longint p, logic [31:0] mv);
    job_t j;
    j.kind = J_ITEM;
    j.action = act;
    j.pos = p[31:0];
    j.mval = mv;
    j.gap = '0;
    pending.push_back(j);
    if (act == ACT_LOAD && gen_count < DEPTH) begin
      gen_count++;
      gen_pos.push_back(p);
      if (p > gen_max) gen_max = p;
    end
  endtask

  task automatic add_cfg(logic [30:0] g);
    job_t j;
    j.kind = J_CFG;
    j.action = 1'b0;
    j.pos = '0;
    j.mval = '0;
    j.gap = g;
    pending.push_back(j);
  endtask

  task automatic add_drain();
    job_t j;
    j.kind = J_DRAIN;
    j.action = 1'b0;
    j.pos = '0;
    j.mval = '0;
    j.gap = '0;
    pending.push_back(j);
  endtask

  function automatic longint rand_step();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 3) return longint'($urandom_range(1, 16));
    if (sel < 8) return longint'($urandom_range(1, 65536));
    return longint'($urandom_range(1, 1 << 22));
  endfunction

  function automatic logic [30:0] rand_gap();
    case ($urandom_range(0, 4))
      0: return 31'd0;
      1: return 31'd16;
      2: return 31'd65536;
      3: return 31'($urandom_range(1, 1 << 22));
      default: return 31'h7FFF_FFFF;
    endcase
  endfunction

  task automatic build_stimulus();
    longint lo, cur, s;
    int unsigned k, m, sel;
    // directed
    add_item(ACT_QUERY, 0, 32'h1234_5678);
    add_item(ACT_QUERY, -1, '0);
    add_item(ACT_QUERY, 5, '0);
    add_item(ACT_QUERY, -64'sd2147483648, 32'hFFFF_FFFF);
    add_item(ACT_LOAD, 100, 32'h0001_0000);
    add_item(ACT_QUERY, 200, '0);
    add_item(ACT_QUERY, 50, '0);
    add_item(ACT_QUERY, 100, '0);
    add_item(ACT_LOAD, 300, 32'hFFFF_FFFF);
    add_item(ACT_QUERY, 250, '0);
    add_item(ACT_QUERY, 1000, '0);
    add_item(ACT_LOAD, 400, 32'h0000_0000);
    add_item(ACT_QUERY, 350, '0);
    add_item(ACT_QUERY, 2147483647, '0);
    add_cfg(31'd10);
    add_item(ACT_QUERY, 390, '0);
    add_cfg(31'd0);
    add_item(ACT_QUERY, 395, '0);
    add_cfg(31'h7FFF_FFFF);
    add_item(ACT_LOAD, 400, 32'h0000_0005);
    add_item(ACT_QUERY, 400, '0);
    add_item(ACT_QUERY, 500, '0);
    add_item(ACT_QUERY, 10, '0);
    add_item(ACT_LOAD, 401, 32'h8000_0000);
    add_item(ACT_LOAD, 2000, 32'h7FFF_FFFF);
    add_item(ACT_QUERY, 1000, '0);
    add_drain();
    // random segments: append entries, then mostly ascending queries inside them
    while (pending.size() < 950) begin
      if (($urandom_range(0, 99) < 2)) add_cfg(rand_gap());
      if ($urandom_range(0, 199) == 0) add_drain();
      lo = gen_max;
      k = (gen_count < 300) ? $urandom_range(1, 3) : 0;
      for (int unsigned n = 0; n < k; n++) begin
        if ($urandom_range(0, 19) == 0)
          add_item(ACT_LOAD, longint'($signed($urandom())), $urandom());
        else
          add_item(ACT_LOAD, gen_max + rand_step(), $urandom());
      end
      cur = lo;
      m = $urandom_range(1, 6);
      for (int unsigned n = 0; n < m; n++) begin
        sel = $urandom_range(0, 99);
        if (sel < 55 && cur < gen_max) begin
          s = gen_max - cur;
          cur = cur + ((s > 64'd4000000000) ? longint'($urandom_range(1, 1 << 30))
                                            : longint'($urandom_range(1, 32'(s))));
          add_item(ACT_QUERY, cur, $urandom());
        end else if (sel < 70 && gen_pos.size() > 0) begin
          add_item(ACT_QUERY, gen_pos[$urandom_range(0, gen_pos.size() - 1)], $urandom());
        end else if (sel < 80) begin
          add_item(ACT_QUERY, gen_max + $urandom_range(1, 1 << 24), $urandom());
        end else if (sel < 85) begin
          add_item(ACT_QUERY, -longint'($urandom_range(1, 32'h7FFF_FFFF)), $urandom());
        end else begin
          add_item(ACT_QUERY, longint'($signed($urandom())), $urandom());
        end
      end
    end
    add_cfg(31'h7FFF_FFFF);
    // fill the table, then overflow it
    while (gen_count < DEPTH) add_item(ACT_LOAD, gen_max + $urandom_range(1, 1000), $urandom());
    for (int n = 0; n < 3; n++) add_item(ACT_LOAD, gen_max + 1, $urandom());
    for (int n = 0; n < 4; n++)
      add_item(ACT_QUERY, gen_pos[$urandom_range(0, gen_pos.size() - 1)], '0);
    add_item(ACT_QUERY, gen_max + 12345, '0);
    add_item(ACT_QUERY, gen_max - 1, '0);
    add_item(ACT_QUERY, -5, '0);
  endtask

  // acceptance sampling and prediction
  always @(posedge clk_i) begin
    in_fire = rst_ni && in_valid_i && !in_stall_o;
    cfg_fire = rst_ni && cfg_valid_i && cfg_ready_o;
    if (rst_ni) cyc++;
    if (in_fire) begin
      lookups_due.push_back(table_lookup(action_i, position_i, map_value_i));
      n_items++;
    end
    if (cfg_fire) begin
      gap_limit = cfg_data_i;
      n_cfg++;
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    lookup_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      status_seen[status_o]++;
      if (lookups_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: status %0d", status_o);
      end else begin
        e = lookups_due.pop_front();
        if (status_o !== e.status || result_value_o !== e.value ||
            entry_index_o !== e.index || success_o !== e.ok) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch at result %0d: exp st %0d val %h idx %0d ok %0b,",
                      " got st %0d val %h idx %0d ok %0b"},
                     n_results, e.status, e.value, e.index, e.ok,
                     status_o, result_value_o, entry_index_o, success_o);
        end
      end
    end
  end

  function automatic bit quiet_window();
    return cyc >= 40000 && cyc < 90000;
  endfunction

  // driver
  always @(negedge clk_i) begin
    logic nv, ncv;
    job_t j;
    nv = in_valid_i;
    ncv = cfg_valid_i;
    if (rst_ni) begin
      if (nv && in_fire) nv = 1'b0;
      if (ncv && cfg_fire) begin
        ncv = 1'b0;
        void'(pending.pop_front());
      end
      if (!nv && !ncv && pending.size() > 0) begin
        j = pending[0];
        case (j.kind)
          J_ITEM: begin
            if (quiet_window() || $urandom_range(0, 99) >= 20) begin
              void'(pending.pop_front());
              action_i <= j.action;
              position_i <= j.pos;
              map_value_i <= j.mval;
              nv = 1'b1;
            end
          end
          J_CFG: begin
            if (lookups_due.size() == 0) begin
              cfg_data_i <= j.gap;
              ncv = 1'b1;
            end
          end
          default: begin
            if (lookups_due.size() == 0) void'(pending.pop_front());
          end
        endcase
      end
      in_valid_i <= nv;
      cfg_valid_i <= ncv;
    end
  end

  // receiver stall, with one long hold-off after the sixtieth accepted transaction
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && n_items == 60) begin
        hold_done <= 1'b1;
        hold_left <= 600;
        out_stall_i <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !quiet_window() && ($urandom_range(0, 99) < 20);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_fire || cfg_fire || (out_valid_o && !out_stall_i)) idle_cyc <= 0;
      else idle_cyc <= idle_cyc + 1;
      if (idle_cyc >= WDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WDOG_LIMIT);
        $display("** sorted_table_linear_interpolator_top: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      pos_tab[i] = '0;
      val_tab[i] = '0;
    end
    build_stimulus();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait (pending.size() == 0 && !in_valid_i && !cfg_valid_i);
    wait (lookups_due.size() == 0);
    repeat (200) @(posedge clk_i);
    if (lookups_due.size() != 0) mismatches++;
    $display("%0d transactions in, %0d results, %0d max_gap writes, %0d cycles",
             n_items, n_results, n_cfg, cyc);
    $display("status mix: exact %0d interp %0d extrap %0d below %0d",
             status_seen[ST_EXACT], status_seen[ST_INTERP], status_seen[ST_EXTRAP],
             status_seen[ST_BELOW]);
    $display("            gap %0d unbr %0d load %0d full %0d",
             status_seen[ST_GAP], status_seen[ST_UNBRACKETED], status_seen[ST_LOADED],
             status_seen[ST_FULL]);
    if (mismatches == 0) begin
      $display("** sorted_table_linear_interpolator_top: PASSED **");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("** sorted_table_linear_interpolator_top: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire
